// ===== sv/mbx_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the two-CPU mailbox FIFO block.
// Depends on nothing; imported by the core.
package mbx_pkg;

   // Words each send FIFO can hold
   localparam int FIFO_DEPTH = 16;
   localparam int IDX_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W      = IDX_W + 1;
   localparam int RAM_ADDR_W = IDX_W + 1;
   localparam int RAM_DEPTH  = 2 ** RAM_ADDR_W;
   localparam int WORD_W     = 32;

   // Bus operation codes
   typedef enum logic [1:0] {
      OP_READ_HALF  = 2'd0,
      OP_READ_RECV  = 2'd1,
      OP_WRITE_HALF = 2'd2,
      OP_WRITE_SEND = 2'd3
   } op_type;

   // Register selector codes
   typedef enum logic [1:0] {
      SEL_SYNC  = 2'd0,
      SEL_CTRL  = 2'd1,
      SEL_SEND  = 2'd2,
      SEL_NONE  = 2'd3
   } sel_type;

   // Interrupt bit positions
   localparam int IRQ_SYNC       = 0;
   localparam int IRQ_SEND_EMPTY = 1;
   localparam int IRQ_RECV_AVAIL = 2;

   // Sync register image bits
   localparam int SYNC_IN_LSB  = 0;
   localparam int SYNC_OUT_LSB = 8;
   localparam int SYNC_IE_BIT  = 14;

   // FIFO control image bits
   localparam int CTL_SEND_EMPTY = 0;
   localparam int CTL_SEND_FULL  = 1;
   localparam int CTL_SEND_IE    = 2;
   localparam int CTL_SEND_CLEAR = 3;
   localparam int CTL_RECV_EMPTY = 8;
   localparam int CTL_RECV_FULL  = 9;
   localparam int CTL_RECV_IE    = 10;
   localparam int CTL_ERROR      = 14;
   localparam int CTL_ENABLE     = 15;

   // Fold an index sum back into the ring
   function automatic logic [IDX_W-1:0] idx_wrap(input logic [IDX_W:0] value);
      logic [IDX_W:0] folded;
      folded = (value >= (IDX_W+1)'(FIFO_DEPTH)) ? value - (IDX_W+1)'(FIFO_DEPTH) : value;
      return folded[IDX_W-1:0];
   endfunction

endpackage

// ===== sv/mbx_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module mbx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, then registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/dual_cpu_mailbox_fifo_core.sv =====
`timescale 1ns / 1ps
// Top level of the two-CPU mailbox: register state, access decode, send FIFOs.
// Depends on mbx_pkg and mbx_ram.

// Each bus access word is taken into an input register; once the output register
// is free or not stalled, its effects are applied and its result word lands in
// the output register, and one access is taken every cycle while the result side
// keeps up. The input register stage matches the FIFO store's registered read
// port: the word at the head of the incoming FIFO is read as the access is
// accepted, with a bypass for a send to the same slot in that cycle. Unwritten
// FIFO slots are never returned as data.
module dual_cpu_mailbox_fifo_core
   import mbx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_side,
   input  logic [1:0]  req_operation,
   input  logic [1:0]  req_reg_select,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic [2:0]  rsp_irq_to_side0,
   output logic [2:0]  rsp_irq_to_side1,
   output logic        rsp_bad_access
);

   // Per-side register state
   logic [3:0]        sync_ff      [2];
   logic [3:0]        sync_in      [2];
   logic              sync_ie_ff   [2];
   logic              sync_ie_in   [2];
   logic [IDX_W-1:0]  head_ff      [2];
   logic [IDX_W-1:0]  head_in      [2];
   logic [CNT_W-1:0]  cnt_ff       [2];
   logic [CNT_W-1:0]  cnt_in       [2];
   logic              send_ie_ff   [2];
   logic              send_ie_in   [2];
   logic              recv_ie_ff   [2];
   logic              recv_ie_in   [2];
   logic              err_ff       [2];
   logic              err_in       [2];
   logic              fen_ff       [2];
   logic              fen_in       [2];
   logic [WORD_W-1:0] last_ff      [2];
   logic [WORD_W-1:0] last_in      [2];

   // Input register
   logic              in_valid_ff;
   logic              in_side_ff;
   op_type            in_op_ff;
   sel_type           in_sel_ff;
   logic [WORD_W-1:0] in_wd_ff;

   // Output register
   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_rd_ff;
   logic [WORD_W-1:0] rsp_rd_in;
   logic [2:0]        rsp_irq_ff   [2];
   logic [2:0]        rsp_irq_in   [2];
   logic              rsp_bad_ff;
   logic              rsp_bad_in;

   // FIFO store access
   logic                  ram_we;
   logic [RAM_ADDR_W-1:0] ram_waddr;
   logic [RAM_ADDR_W-1:0] ram_raddr;
   logic [WORD_W-1:0]     ram_rdata;
   logic                  byp_ff;
   logic [WORD_W-1:0]     byp_data_ff;
   logic                  byp_in;
   logic [WORD_W-1:0]     front_word;

   // Handshake
   logic              fire;
   logic              req_take;
   logic              s;
   logic              o;
   logic [15:0]       hw;
   logic              own_empty;
   logic              oth_empty;

   assign fire      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   assign s          = in_side_ff;
   assign o          = ~in_side_ff;
   assign hw         = in_wd_ff[15:0];
   assign own_empty  = (cnt_ff[s] == '0);
   assign oth_empty  = (cnt_ff[o] == '0);
   assign front_word = byp_ff ? byp_data_ff : ram_rdata;

   // Apply the held access word to the state and form its result
   always_comb begin
      sync_in    = sync_ff;
      sync_ie_in = sync_ie_ff;
      head_in    = head_ff;
      cnt_in     = cnt_ff;
      send_ie_in = send_ie_ff;
      recv_ie_in = recv_ie_ff;
      err_in     = err_ff;
      fen_in     = fen_ff;
      last_in    = last_ff;
      rsp_rd_in  = '0;
      rsp_irq_in = '{default: 3'b000};
      rsp_bad_in = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = {s, idx_wrap({1'b0, head_ff[s]} + cnt_ff[s][IDX_W:0])};
      if (fire) begin
         unique case (in_op_ff)
            OP_READ_HALF: begin
               case (in_sel_ff)
                  SEL_SYNC: begin
                     rsp_rd_in[SYNC_IN_LSB +: 4]  = sync_ff[o];
                     rsp_rd_in[SYNC_OUT_LSB +: 4] = sync_ff[s];
                     rsp_rd_in[SYNC_IE_BIT]       = sync_ie_ff[s];
                  end
                  SEL_CTRL: begin
                     rsp_rd_in[CTL_SEND_EMPTY] = own_empty;
                     rsp_rd_in[CTL_SEND_FULL]  = (cnt_ff[s] == CNT_W'(FIFO_DEPTH));
                     rsp_rd_in[CTL_SEND_IE]    = send_ie_ff[s];
                     rsp_rd_in[CTL_RECV_EMPTY] = oth_empty;
                     rsp_rd_in[CTL_RECV_FULL]  = (cnt_ff[o] == CNT_W'(FIFO_DEPTH));
                     rsp_rd_in[CTL_RECV_IE]    = recv_ie_ff[s];
                     rsp_rd_in[CTL_ERROR]      = err_ff[s];
                     rsp_rd_in[CTL_ENABLE]     = fen_ff[s];
                  end
                  default: begin
                     rsp_bad_in = 1'b1;
                  end
               endcase
            end
            OP_READ_RECV: begin
               if (fen_ff[s]) begin
                  if (!oth_empty) begin
                     // Pop the other side's send FIFO
                     last_in[s] = front_word;
                     head_in[o] = idx_wrap({1'b0, head_ff[o]} + (IDX_W+1)'(1));
                     cnt_in[o]  = cnt_ff[o] - CNT_W'(1);
                     if ((cnt_ff[o] == CNT_W'(1)) && send_ie_ff[o]) begin
                        rsp_irq_in[o][IRQ_SEND_EMPTY] = 1'b1;
                     end
                  end else begin
                     err_in[s] = 1'b1;
                  end
               end else begin
                  // Peek without removing
                  last_in[s] = oth_empty ? '0 : front_word;
               end
               rsp_rd_in = last_in[s];
            end
            OP_WRITE_HALF: begin
               case (in_sel_ff)
                  SEL_SYNC: begin
                     sync_in[s]    = hw[SYNC_OUT_LSB +: 4];
                     sync_ie_in[s] = hw[SYNC_IE_BIT];
                     if (sync_ie_ff[o]) begin
                        rsp_irq_in[o][IRQ_SYNC] = 1'b1;
                     end
                  end
                  SEL_CTRL: begin
                     if (hw[CTL_SEND_CLEAR]) begin
                        head_in[s] = '0;
                        cnt_in[s]  = '0;
                        last_in[s] = '0;
                     end
                     if (hw[CTL_ERROR]) begin
                        err_in[s] = 1'b0;
                     end
                     if (hw[CTL_SEND_IE] && !send_ie_ff[s]
                         && (hw[CTL_SEND_CLEAR] || own_empty)) begin
                        rsp_irq_in[s][IRQ_SEND_EMPTY] = 1'b1;
                     end
                     if (hw[CTL_RECV_IE] && !recv_ie_ff[s] && !oth_empty) begin
                        rsp_irq_in[s][IRQ_RECV_AVAIL] = 1'b1;
                     end
                     send_ie_in[s] = hw[CTL_SEND_IE];
                     recv_ie_in[s] = hw[CTL_RECV_IE];
                     fen_in[s]     = hw[CTL_ENABLE];
                  end
                  default: begin
                     rsp_bad_in = 1'b1;
                  end
               endcase
            end
            OP_WRITE_SEND: begin
               if (in_sel_ff == SEL_SEND) begin
                  if (fen_ff[s]) begin
                     if (cnt_ff[s] < CNT_W'(FIFO_DEPTH)) begin
                        // Push at the tail of the own send FIFO
                        ram_we    = 1'b1;
                        cnt_in[s] = cnt_ff[s] + CNT_W'(1);
                        if (recv_ie_ff[o] && own_empty) begin
                           rsp_irq_in[o][IRQ_RECV_AVAIL] = 1'b1;
                        end
                     end else begin
                        err_in[s] = 1'b1;
                     end
                  end
               end else begin
                  rsp_bad_in = 1'b1;
               end
            end
         endcase
      end
   end

   // Read the incoming FIFO head for the word being accepted
   assign ram_raddr = {~req_side, head_in[~req_side]};
   assign byp_in    = ram_we && (ram_waddr == ram_raddr);

   mbx_ram #(
      .WIDTH (WORD_W),
      .DEPTH (RAM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (in_wd_ff),
      .rd_en   (req_take),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Hold state, input and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sync_ff      <= '{default: 4'h0};
         sync_ie_ff   <= '{default: 1'b0};
         head_ff      <= '{default: '0};
         cnt_ff       <= '{default: '0};
         send_ie_ff   <= '{default: 1'b0};
         recv_ie_ff   <= '{default: 1'b0};
         err_ff       <= '{default: 1'b0};
         fen_ff       <= '{default: 1'b0};
         last_ff      <= '{default: '0};
      end else begin
         sync_ff    <= sync_in;
         sync_ie_ff <= sync_ie_in;
         head_ff    <= head_in;
         cnt_ff     <= cnt_in;
         send_ie_ff <= send_ie_in;
         recv_ie_ff <= recv_ie_in;
         err_ff     <= err_in;
         fen_ff     <= fen_in;
         last_ff    <= last_in;
         // Advance the input register
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         // Advance the output register
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      // Payload registers
      if (req_take) begin
         in_side_ff  <= req_side;
         in_op_ff    <= op_type'(req_operation);
         in_sel_ff   <= sel_type'(req_reg_select);
         in_wd_ff    <= req_write_data;
         byp_ff      <= byp_in;
         byp_data_ff <= in_wd_ff;
      end
      if (fire) begin
         rsp_rd_ff  <= rsp_rd_in;
         rsp_irq_ff <= rsp_irq_in;
         rsp_bad_ff <= rsp_bad_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_rd_ff;
   assign rsp_irq_to_side0 = rsp_irq_ff[0];
   assign rsp_irq_to_side1 = rsp_irq_ff[1];
   assign rsp_bad_access   = rsp_bad_ff;

   // FIFO fill never passes its depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff[0] <= CNT_W'(FIFO_DEPTH)) && (cnt_ff[1] <= CNT_W'(FIFO_DEPTH)))
      else $error("send FIFO count above depth");

   // A held result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(fire && rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

   // An unmapped access changes no FIFO or flag state
   a_bad_no_change: assert property (@(posedge clock) disable iff (reset)
      (fire && rsp_bad_in) |=> ($stable(cnt_ff[0]) && $stable(cnt_ff[1])
                                && $stable(head_ff[0]) && $stable(head_ff[1])
                                && $stable(err_ff[0]) && $stable(err_ff[1])
                                && $stable(last_ff[0]) && $stable(last_ff[1])))
      else $error("unmapped access changed state");

   // An unmapped access returns nothing
   a_bad_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> ((rsp_rd_ff == '0)
         && (rsp_irq_ff[0] == 3'b000) && (rsp_irq_ff[1] == 3'b000)))
      else $error("unmapped access returned data or interrupts");

endmodule

// ===== verif/dual_cpu_mailbox_fifo_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the two-CPU mailbox: directed, then random bus accesses from both sides,
// with results predicted and checked word by word. Depends on mbx_pkg and the core.
module dual_cpu_mailbox_fifo_core_tb;
   import mbx_pkg::*;

   // One bus access as driven on the request channel
   typedef struct {
      logic        side;
      op_type      op;
      sel_type     sel;
      logic [31:0] wdata;
   } access_type;

   // One result word as seen on the response channel
   typedef struct packed {
      logic [31:0] read_data;
      logic [2:0]  irq0;
      logic [2:0]  irq1;
      logic        bad;
   } reply_type;

   localparam int RANDOM_ITEMS = 1350;
   localparam int CALM_FIRST   = 500;
   localparam int CALM_LAST    = 800;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_side = 1'b0;
   logic [1:0]  req_operation = 2'd0;
   logic [1:0]  req_reg_select = 2'd0;
   logic [31:0] req_write_data = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_read_data;
   logic [2:0]  rsp_irq_to_side0;
   logic [2:0]  rsp_irq_to_side1;
   logic        rsp_bad_access;

   access_type access_queue[$];
   reply_type  pending_replies[$];
   int         words_sent = 0;
   int         words_checked = 0;
   int         fail_count = 0;

   // Mirror of the mailbox state, one entry per side
   logic [3:0]       sync_val  [2] = '{default: '0};
   logic             sync_ie   [2] = '{default: '0};
   logic [31:0]      fifo_mem  [2][FIFO_DEPTH];
   logic [IDX_W-1:0] fifo_rd   [2] = '{default: '0};
   logic [CNT_W-1:0] fifo_fill [2] = '{default: '0};
   logic             send_ie   [2] = '{default: '0};
   logic             recv_ie   [2] = '{default: '0};
   logic             err_flag  [2] = '{default: '0};
   logic             fifo_on   [2] = '{default: '0};
   logic [31:0]      last_rx   [2] = '{default: '0};

   dual_cpu_mailbox_fifo_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_side         (req_side),
      .req_operation    (req_operation),
      .req_reg_select   (req_reg_select),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_irq_to_side0 (rsp_irq_to_side0),
      .rsp_irq_to_side1 (rsp_irq_to_side1),
      .rsp_bad_access   (rsp_bad_access)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Apply one access to the mirrored state and return the reply it should produce
   function automatic reply_type apply_access(input access_type a);
      reply_type  r;
      logic       s;
      logic       o;
      logic [15:0] hw;
      logic [2:0] irq [2];
      logic       sen;
      logic       ren;
      int         slot;
      r      = '0;
      s      = a.side;
      o      = ~a.side;
      hw     = a.wdata[15:0];
      irq[0] = '0;
      irq[1] = '0;
      case (a.op)
         OP_READ_HALF: begin
            if (a.sel == SEL_SYNC) begin
               r.read_data = 32'(sync_val[o]) << SYNC_IN_LSB
                           | 32'(sync_val[s]) << SYNC_OUT_LSB
                           | 32'(sync_ie[s]) << SYNC_IE_BIT;
            end else if (a.sel == SEL_CTRL) begin
               r.read_data[CTL_SEND_EMPTY] = (fifo_fill[s] == 0);
               r.read_data[CTL_SEND_FULL]  = (fifo_fill[s] == CNT_W'(FIFO_DEPTH));
               r.read_data[CTL_SEND_IE]    = send_ie[s];
               r.read_data[CTL_RECV_EMPTY] = (fifo_fill[o] == 0);
               r.read_data[CTL_RECV_FULL]  = (fifo_fill[o] == CNT_W'(FIFO_DEPTH));
               r.read_data[CTL_RECV_IE]    = recv_ie[s];
               r.read_data[CTL_ERROR]      = err_flag[s];
               r.read_data[CTL_ENABLE]     = fifo_on[s];
            end else begin
               r.bad = 1'b1;
            end
         end
         OP_READ_RECV: begin
            // Pop the incoming FIFO when enabled, otherwise only peek at its head
            if (fifo_on[s]) begin
               if (fifo_fill[o] != 0) begin
                  last_rx[s]   = fifo_mem[o][fifo_rd[o]];
                  fifo_rd[o]   = (int'(fifo_rd[o]) == FIFO_DEPTH - 1) ? '0 : fifo_rd[o] + 1'b1;
                  fifo_fill[o] = fifo_fill[o] - 1'b1;
                  if (fifo_fill[o] == 0 && send_ie[o])
                     irq[o][IRQ_SEND_EMPTY] = 1'b1;
               end else begin
                  err_flag[s] = 1'b1;
               end
            end else begin
               last_rx[s] = (fifo_fill[o] != 0) ? fifo_mem[o][fifo_rd[o]] : '0;
            end
            r.read_data = last_rx[s];
         end
         OP_WRITE_HALF: begin
            if (a.sel == SEL_SYNC) begin
               sync_val[s] = hw[SYNC_OUT_LSB +: 4];
               sync_ie[s]  = hw[SYNC_IE_BIT];
               if (sync_ie[o])
                  irq[o][IRQ_SYNC] = 1'b1;
            end else if (a.sel == SEL_CTRL) begin
               sen = hw[CTL_SEND_IE];
               ren = hw[CTL_RECV_IE];
               if (hw[CTL_SEND_CLEAR]) begin
                  fifo_rd[s]   = '0;
                  fifo_fill[s] = '0;
                  last_rx[s]   = '0;
               end
               if (hw[CTL_ERROR])
                  err_flag[s] = 1'b0;
               // Enable edges raise an interrupt when the condition already holds
               if (sen && !send_ie[s] && fifo_fill[s] == 0)
                  irq[s][IRQ_SEND_EMPTY] = 1'b1;
               if (ren && !recv_ie[s] && fifo_fill[o] != 0)
                  irq[s][IRQ_RECV_AVAIL] = 1'b1;
               send_ie[s] = sen;
               recv_ie[s] = ren;
               fifo_on[s] = hw[CTL_ENABLE];
            end else begin
               r.bad = 1'b1;
            end
         end
         default: begin
            if (a.sel == SEL_SEND) begin
               // Push, or flag an overflow; drop silently while disabled
               if (fifo_on[s]) begin
                  if (fifo_fill[s] < CNT_W'(FIFO_DEPTH)) begin
                     if (recv_ie[o] && fifo_fill[s] == 0)
                        irq[o][IRQ_RECV_AVAIL] = 1'b1;
                     slot = (int'(fifo_rd[s]) + int'(fifo_fill[s])) % FIFO_DEPTH;
                     fifo_mem[s][slot] = a.wdata;
                     fifo_fill[s] = fifo_fill[s] + 1'b1;
                  end else begin
                     err_flag[s] = 1'b1;
                  end
               end
            end else begin
               r.bad = 1'b1;
            end
         end
      endcase
      r.irq0 = irq[0];
      r.irq1 = irq[1];
      return r;
   endfunction

   task automatic queue_access(input logic side, input op_type op, input sel_type sel,
                               input logic [31:0] data);
      access_type a;
      a.side  = side;
      a.op    = op;
      a.sel   = sel;
      a.wdata = data;
      access_queue.push_back(a);
   endtask

   // Request driver: hold a stalled word, advance on acceptance, idle at random
   always @(posedge clock) begin
      access_type a;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            a = '{req_side, op_type'(req_operation), sel_type'(req_reg_select),
                  req_write_data};
            pending_replies.push_back(apply_access(a));
            words_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (access_queue.size() != 0 &&
                ((words_sent >= CALM_FIRST && words_sent < CALM_LAST) ||
                 $urandom_range(0, 99) >= 30)) begin
               a = access_queue.pop_front();
               req_valid      <= 1'b1;
               req_side       <= a.side;
               req_operation  <= a.op;
               req_reg_select <= a.sel;
               req_write_data <= a.wdata;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: compare each accepted word against the oldest prediction
   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_replies.size() == 0) begin
               $error("unexpected response word, read_data %h", rsp_read_data);
               fail_count++;
            end else begin
               want = pending_replies.pop_front();
               if (rsp_read_data !== want.read_data) begin
                  $error("read_data: expected %h, got %h", want.read_data, rsp_read_data);
                  fail_count++;
               end
               if (rsp_irq_to_side0 !== want.irq0) begin
                  $error("irq_to_side0: expected %h, got %h", want.irq0, rsp_irq_to_side0);
                  fail_count++;
               end
               if (rsp_irq_to_side1 !== want.irq1) begin
                  $error("irq_to_side1: expected %h, got %h", want.irq1, rsp_irq_to_side1);
                  fail_count++;
               end
               if (rsp_bad_access !== want.bad) begin
                  $error("bad_access: expected %b, got %b", want.bad, rsp_bad_access);
                  fail_count++;
               end
            end
            words_checked++;
         end
         rsp_stall <= !(words_checked >= CALM_FIRST && words_checked < CALM_LAST) &&
                      ($urandom_range(0, 99) < 30);
      end
   end

   // Stimulus, reset and end of run
   initial begin
      int    target;
      int    pick;
      int    len;
      logic  s;
      logic [31:0] d;

      // Reset images and unmapped-register faults
      queue_access(1'b0, OP_READ_HALF,  SEL_SYNC, 32'h0);
      queue_access(1'b1, OP_READ_HALF,  SEL_CTRL, 32'h0);
      queue_access(1'b0, OP_READ_HALF,  SEL_SEND, 32'h0);
      queue_access(1'b1, OP_READ_HALF,  SEL_NONE, 32'hFFFF_FFFF);
      queue_access(1'b0, OP_WRITE_HALF, SEL_SEND, 32'hFFFF_FFFF);
      queue_access(1'b1, OP_WRITE_HALF, SEL_NONE, 32'hFFFF_FFFF);
      queue_access(1'b0, OP_WRITE_SEND, SEL_SYNC, 32'hA5A5_A5A5);
      queue_access(1'b1, OP_WRITE_SEND, SEL_NONE, 32'h5A5A_5A5A);
      // Disabled FIFO: empty receive returns zero, send is dropped
      queue_access(1'b0, OP_READ_RECV,  SEL_NONE, 32'h0);
      queue_access(1'b0, OP_WRITE_SEND, SEL_SEND, 32'h1234_5678);
      // Sync exchange with the interrupt enabled on side 1
      queue_access(1'b1, OP_WRITE_HALF, SEL_SYNC, 32'hFFFF_4F00);
      queue_access(1'b0, OP_WRITE_HALF, SEL_SYNC, 32'h0000_0300);
      queue_access(1'b1, OP_READ_HALF,  SEL_SYNC, 32'h0);
      // Enable both FIFOs with both interrupt enables
      queue_access(1'b0, OP_WRITE_HALF, SEL_CTRL, 32'h0000_8404);
      queue_access(1'b1, OP_WRITE_HALF, SEL_CTRL, 32'h0000_8404);
      // Receive from an empty enabled FIFO sets the error flag
      queue_access(1'b1, OP_READ_RECV,  SEL_SYNC, 32'h0);
      queue_access(1'b1, OP_READ_HALF,  SEL_CTRL, 32'h0);
      queue_access(1'b0, OP_WRITE_SEND, SEL_SEND, 32'hFFFF_FFFF);
      queue_access(1'b0, OP_WRITE_SEND, SEL_SEND, 32'h8000_0001);
      // Peek while disabled and clear the error, then drain the FIFO
      queue_access(1'b1, OP_WRITE_HALF, SEL_CTRL, 32'h0000_4400);
      queue_access(1'b1, OP_READ_RECV,  SEL_CTRL, 32'h0);
      queue_access(1'b1, OP_WRITE_HALF, SEL_CTRL, 32'h0000_8404);
      queue_access(1'b1, OP_READ_RECV,  SEL_SEND, 32'h0);
      queue_access(1'b1, OP_READ_RECV,  SEL_NONE, 32'h0);
      // Send clear drops queued words and the last received word
      queue_access(1'b1, OP_WRITE_SEND, SEL_SEND, 32'hDEAD_BEEF);
      queue_access(1'b1, OP_WRITE_HALF, SEL_CTRL, 32'h0000_840C);

      // Random part: mostly well-formed bursts, some noise
      target = access_queue.size() + RANDOM_ITEMS;
      while (access_queue.size() < target) begin
         pick = $urandom_range(0, 99);
         s    = $urandom_range(0, 1);
         len  = $urandom_range(1, 20);
         if (pick < 10) begin
            d = $urandom;
            d[CTL_ENABLE] = 1'b1;
            d[CTL_SEND_CLEAR] = ($urandom_range(0, 7) == 0);
            queue_access(s, OP_WRITE_HALF, SEL_CTRL, d);
         end else if (pick < 40) begin
            repeat (len) queue_access(s, OP_WRITE_SEND, SEL_SEND, $urandom);
         end else if (pick < 65) begin
            repeat (len) queue_access(s, OP_READ_RECV, sel_type'($urandom_range(0, 3)),
                                      $urandom);
         end else if (pick < 75) begin
            queue_access(s, OP_WRITE_HALF, SEL_SYNC, $urandom);
            queue_access(~s, OP_READ_HALF, SEL_SYNC, $urandom);
         end else if (pick < 85) begin
            queue_access(s, OP_READ_HALF, sel_type'($urandom_range(0, 1)), $urandom);
         end else if (pick < 95) begin
            d = $urandom;
            if ($urandom_range(0, 3) != 0)
               d[CTL_ENABLE] = 1'b1;
            queue_access(s, OP_WRITE_HALF, SEL_CTRL, d);
         end else begin
            queue_access(s, op_type'($urandom_range(0, 3)), sel_type'($urandom_range(0, 3)),
                         $urandom);
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Drain: all words sent, all replies checked, then let the design settle before the verdict
      while (access_queue.size() != 0 || req_valid || pending_replies.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_replies.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #3_600_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/mbx_pkg.sv
sv/mbx_ram.sv
sv/dual_cpu_mailbox_fifo_core.sv
verif/dual_cpu_mailbox_fifo_core_tb.sv
